// File: hdl/stt_pkg.sv
// Shared types and constants for the software timer table.
package stt_pkg;

    localparam int SLOTS_DEFAULT = 16;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_POST_ONE = 3'd1,
        OP_POST_PER = 3'd2,
        OP_REMOVE   = 3'd3,
        OP_CLEAR    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        KIND_FIRED = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FULL  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SEARCH,
        ST_WRITE,
        ST_REPLY,
        ST_FIRE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the request fields and reset the position
        logic tick_start;  // reset the kept count
        logic tick_step;   // process one firing-order position
        logic search_step; // examine one firing-order position for the key
        logic post_write;  // write the slot and push it to the front
        logic remove_do;   // detach the found timer and free it
        logic clear_all;   // free every timer
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic walk_done;   // tick walk finished all positions
        logic fire;        // the current tick step fires a timer
        logic search_done; // key search finished
        logic have_slot;   // post has a slot to use
    } sts_t;

endpackage

// File: hdl/stt_datapath.sv
// Timer storage, firing order and the per-step tick and search logic.
module stt_datapath
    import stt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [2:0]  op,
    input  logic [15:0] callback_key,
    input  logic [31:0] context_handle,
    input  logic [31:0] initial_delay,
    input  logic [31:0] repeat_period,
    output logic [2:0]  op_q,
    output logic [15:0] fire_key,
    output logic [31:0] fire_context
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    logic [SLOTS-1:0]  busy_reg;
    logic [15:0]       key_mem    [SLOTS];
    logic [31:0]       ctx_mem    [SLOTS];
    logic [31:0]       rem_mem    [SLOTS];
    logic [31:0]       per_mem    [SLOTS];
    logic              prd_mem    [SLOTS];
    logic [IW-1:0]     order_reg  [SLOTS];
    logic [CW-1:0]     active_reg;

    logic [2:0]        op_reg;
    logic [15:0]       key_reg;
    logic [31:0]       ctx_reg, delay_reg, period_reg;
    logic [CW-1:0]     pos_reg;    // walk or search position
    logic [CW-1:0]     kept_reg;
    logic              found_reg;
    logic [CW-1:0]     found_pos_reg;
    logic [IW-1:0]     found_slot_reg;

    logic [IW-1:0]     cur_slot;
    logic [31:0]       dec_val;
    logic              fires;
    logic [IW-1:0]     free_slot;
    logic              free_any;
    logic              hit;

    assign cur_slot = order_reg[pos_reg[IW-1:0]];
    assign dec_val  = (rem_mem[cur_slot] != 32'd0) ? rem_mem[cur_slot] - 32'd1 : 32'd0;
    assign fires    = (dec_val == 32'd0);
    assign hit      = busy_reg[cur_slot] && (key_mem[cur_slot] == key_reg);

    always_comb
    begin
        free_slot = '0;
        free_any  = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_slot = IW'(i);
                free_any  = 1'b1;
            end
        end
    end

    assign sts.walk_done   = (pos_reg >= active_reg);
    assign sts.fire        = fires;
    assign sts.search_done = found_reg || (pos_reg >= active_reg);
    assign sts.have_slot   = found_reg || free_any;

    assign op_q         = op_reg;
    assign fire_key     = key_mem[cur_slot];
    assign fire_context = ctx_mem[cur_slot];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= '0;
            active_reg <= '0;
            pos_reg    <= '0;
            kept_reg   <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                pos_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.tick_start)
            begin
                kept_reg <= '0;
            end
            if (cmd.tick_step)
            begin
                pos_reg <= pos_reg + CW'(1);
                if (fires && prd_mem[cur_slot])
                    rem_mem[cur_slot] <= per_mem[cur_slot];
                else
                    rem_mem[cur_slot] <= dec_val;
                if (fires && !prd_mem[cur_slot])
                    busy_reg[cur_slot] <= 1'b0;
                else
                begin
                    order_reg[kept_reg[IW-1:0]] <= cur_slot;
                    kept_reg <= kept_reg + CW'(1);
                end
                if (pos_reg + CW'(1) >= active_reg)
                    active_reg <= kept_reg + CW'((fires && !prd_mem[cur_slot]) ? 0 : 1);
            end
            if (cmd.search_step)
            begin
                if (hit)
                begin
                    found_reg      <= 1'b1;
                    found_pos_reg  <= pos_reg;
                    found_slot_reg <= cur_slot;
                end
                else
                    pos_reg <= pos_reg + CW'(1);
            end
            if (cmd.post_write)
            begin
                // Positions ahead of the detached one shift back by one;
                // with no detach, all active positions shift.
                for (int q = SLOTS - 1; q > 0; q--)
                begin
                    if (found_reg ? (CW'(q) <= found_pos_reg) : (CW'(q) <= active_reg))
                        order_reg[q] <= order_reg[q-1];
                end
                if (found_reg || active_reg < CW'(SLOTS))
                begin
                    order_reg[0] <= found_reg ? found_slot_reg : free_slot;
                    if (!found_reg)
                        active_reg <= active_reg + CW'(1);
                end
                begin
                    logic [IW-1:0] s;
                    s = found_reg ? found_slot_reg : free_slot;
                    busy_reg[s] <= 1'b1;
                    key_mem[s]  <= key_reg;
                    ctx_mem[s]  <= ctx_reg;
                    rem_mem[s]  <= delay_reg;
                    prd_mem[s]  <= (op_reg == OP_POST_PER);
                    per_mem[s]  <= (op_reg == OP_POST_PER) ? period_reg : 32'd0;
                end
            end
            if (cmd.remove_do && found_reg)
            begin
                for (int q = 0; q < SLOTS - 1; q++)
                begin
                    if (CW'(q) >= found_pos_reg)
                        order_reg[q] <= order_reg[q+1];
                end
                active_reg <= active_reg - CW'(1);
                busy_reg[found_slot_reg] <= 1'b0;
            end
            if (cmd.clear_all)
            begin
                busy_reg   <= '0;
                active_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op;
            key_reg    <= callback_key;
            ctx_reg    <= context_handle;
            delay_reg  <= initial_delay;
            period_reg <= repeat_period;
        end
    end

endmodule

// File: hdl/stt_control.sv
// Sequencer that steps the datapath through each request and drives the result port.
module stt_control
    import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [2:0]  op_q,
    output cmd_t        cmd,
    input  sts_t        sts,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic        last
);
    state_t state_reg, state_next;
    logic [1:0] kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= KIND_DONE;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        kind       = kind_reg;
        last       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    kind_next   = KIND_DONE;
                    case (op)
                        OP_TICK:
                        begin
                            cmd.tick_start = 1'b1;
                            state_next     = ST_TICK;
                        end
                        OP_POST_ONE, OP_POST_PER, OP_REMOVE:
                            state_next = ST_SEARCH;
                        OP_CLEAR:
                        begin
                            cmd.clear_all = 1'b1;
                            state_next    = ST_REPLY;
                        end
                        default:
                            state_next = ST_REPLY;
                    endcase
                end
            end
            ST_TICK:
            begin
                if (sts.walk_done)
                    state_next = ST_REPLY;
                else if (sts.fire)
                    state_next = ST_FIRE;
                else
                    cmd.tick_step = 1'b1;
            end
            ST_FIRE:
            begin
                out_valid = 1'b1;
                kind      = KIND_FIRED;
                last      = 1'b0;
                if (out_ready)
                begin
                    cmd.tick_step = 1'b1;
                    state_next    = ST_TICK;
                end
            end
            ST_SEARCH:
            begin
                if (sts.search_done)
                    state_next = ST_WRITE;
                else
                    cmd.search_step = 1'b1;
            end
            ST_WRITE:
            begin
                state_next = ST_REPLY;
                if (op_q == OP_REMOVE)
                    cmd.remove_do = 1'b1;
                else if (sts.have_slot)
                    cmd.post_write = 1'b1;
                else
                    kind_next = KIND_FULL;
            end
            ST_REPLY:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// File: hdl/software_timer_table.sv
// Software timer table: a tick walks the active timers one per cycle in
// firing order, pausing at each timer that fires until the consumer takes
// its fired result. A post or remove searches the firing order one position
// per cycle for the key; a clear or an unused code goes straight to the
// reply. One request is handled at a time.
module software_timer_table
    import stt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [15:0] callback_key,
    input  logic [31:0] context_handle,
    input  logic [31:0] initial_delay,
    input  logic [31:0] repeat_period,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] fired_key,
    output logic [31:0] fired_context,
    output logic        last
);
    cmd_t        cmd;
    sts_t        sts;
    logic [2:0]  op_q;
    logic [15:0] fire_key;
    logic [31:0] fire_context;

    stt_datapath #(.SLOTS(SLOTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .op(op), .callback_key(callback_key), .context_handle(context_handle),
        .initial_delay(initial_delay), .repeat_period(repeat_period),
        .op_q(op_q), .fire_key(fire_key), .fire_context(fire_context)
    );

    stt_control u_ctl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .op_q(op_q), .cmd(cmd), .sts(sts),
        .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .last(last)
    );

    assign fired_key     = (kind == KIND_FIRED) ? fire_key : 16'd0;
    assign fired_context = (kind == KIND_FIRED) ? fire_context : 32'd0;

endmodule
